@@ hdl/ddft_pkg.sv @@
// Package for the direct DFT frame block: sizes, controller/datapath links
// and the twiddle ROM contents, built at elaboration.
// No dependencies.
package ddft_pkg;

  // Frame and word sizes.
  localparam int FRAME_LEN    = 1024;
  localparam int SAMPLE_BITS  = 16;
  localparam int TWIDDLE_BITS = 16;
  localparam int BIN_W        = 10;
  localparam int ACC_W        = 42;
  localparam int IDX_W        = $clog2(FRAME_LEN);
  localparam int CNT_W        = IDX_W + 1;
  localparam int M_W          = (BIN_W > IDX_W) ? BIN_W : IDX_W;
  localparam int PROD_W       = SAMPLE_BITS + TWIDDLE_BITS;
  localparam int ROM_W        = 2 * TWIDDLE_BITS;

  // Fixed-point constants of the table generator (Q30).
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] PIH_Q30 = 64'd1686629713;

  typedef logic [ROM_W-1:0] twd_word_t;
  typedef twd_word_t        twd_rom_t [FRAME_LEN];
  typedef logic signed [TWIDDLE_BITS-1:0] twd_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // write a sample at the write position
    logic start;    // latch the bin, clear the sums and the address counters
    logic reduce;   // take the bin down by one frame length
    logic issue;    // read one sample and twiddle into the pipeline
    logic publish;  // copy the sums into the output register
  } ddft_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic m_ok;       // bin is below the frame length
    logic last_issue; // the current read is the last of the frame
    logic pipe_busy;  // products are still in flight
  } ddft_stat_t;

  // Clamp a Q30 value to [0, 1], round half up and saturate.
  function automatic twd_t to_twiddle(input logic signed [63:0] v);
    logic signed [63:0] w;
    logic signed [63:0] r;
    logic signed [63:0] maxv;
    w    = v;
    maxv = (64'sd1 <<< (TWIDDLE_BITS - 1)) - 64'sd1;
    if (w < 0) begin
      w = 0;
    end
    if (w > $signed(Q30_ONE)) begin
      w = $signed(Q30_ONE);
    end
    r = (w + (64'sd1 <<< (30 - TWIDDLE_BITS))) >>> (31 - TWIDDLE_BITS);
    if (r > maxv) begin
      r = maxv;
    end
    return TWIDDLE_BITS'(r);
  endfunction

  // One ROM entry {cos, sin} for angle 2*pi*k/FRAME_LEN, by Taylor series.
  function automatic twd_word_t twiddle_entry(input int k);
    logic [63:0] four;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] ts;
    logic [63:0] tc;
    logic signed [63:0] s;
    logic signed [63:0] c;
    twd_t cv;
    twd_t sv;
    twd_t co;
    twd_t so;
    four = 64'(k) * 64'd4;
    q    = four / FRAME_LEN;
    r    = four - q * 64'(FRAME_LEN);
    t    = (PIH_Q30 * r) / FRAME_LEN;
    t2   = (t * t) >> 30;
    ts   = t;
    tc   = Q30_ONE;
    s    = 0;
    c    = 0;
    for (int j = 0; j < 14; j++) begin
      if ((j & 1) != 0) begin
        s = s - $signed(ts);
        c = c - $signed(tc);
      end else begin
        s = s + $signed(ts);
        c = c + $signed(tc);
      end
      ts = ((ts * t2) >> 30) / 64'((2 * j + 2) * (2 * j + 3));
      tc = ((tc * t2) >> 30) / 64'((2 * j + 1) * (2 * j + 2));
    end
    cv = to_twiddle(c);
    sv = to_twiddle(s);
    case (q[1:0])
      2'd0: begin
        co = cv;
        so = sv;
      end
      2'd1: begin
        co = -sv;
        so = cv;
      end
      2'd2: begin
        co = -cv;
        so = -sv;
      end
      default: begin
        co = sv;
        so = -cv;
      end
    endcase
    return {co, so};
  endfunction

  function automatic twd_rom_t build_rom();
    twd_rom_t rom;
    for (int k = 0; k < FRAME_LEN; k++) begin
      rom[k] = twiddle_entry(k);
    end
    return rom;
  endfunction

  // Cosine in the upper half of each word, sine in the lower half.
  localparam twd_rom_t TWIDDLE_ROM = build_rom();

endpackage

@@ hdl/ddft_ctrl.sv @@
// Controller of the direct DFT frame block: input and output handshakes
// and the sequencing of one bin request. Depends on ddft_pkg.
module ddft_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                mode_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ddft_pkg::ddft_cmd_t cmd_o,
  input  ddft_pkg::ddft_stat_t stat_i
);
  import ddft_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_RUN,
    ST_FLUSH,
    ST_HOLD
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_valid_d;
  logic   in_take;
  logic   out_free;

  // Items are taken only between requests; loads finish in the accept cycle.
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_take     = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  // Commands follow from the state and the accepted transaction.
  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = in_take && !mode_i;
    cmd_o.start   = in_take && mode_i;
    cmd_o.reduce  = (state_q == ST_REDUCE) && !stat_i.m_ok;
    cmd_o.issue   = (state_q == ST_RUN);
    cmd_o.publish = (state_q == ST_HOLD) && out_free;
  end

  // The output valid flag drops when its transaction is taken and rises on
  // a new result; a result may replace one that leaves in the same cycle.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == ST_HOLD) && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  // State register and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_IDLE: begin
          if (in_take && mode_i) begin
            state_q <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          if (stat_i.m_ok) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (stat_i.last_issue) begin
            state_q <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (!stat_i.pipe_busy) begin
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hdl/ddft_datapath.sv @@
// Datapath of the direct DFT frame block: frame store, twiddle ROM,
// multiply-accumulate pipeline and result register. Depends on ddft_pkg.
module ddft_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ddft_pkg::ddft_cmd_t               cmd_i,
  output ddft_pkg::ddft_stat_t              stat_o,
  input  logic signed [ddft_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic [ddft_pkg::BIN_W-1:0]        bin_index_i,
  output logic signed [ddft_pkg::ACC_W-1:0] bin_real_o,
  output logic signed [ddft_pkg::ACC_W-1:0] bin_imag_o,
  output logic [ddft_pkg::BIN_W-1:0]        bin_number_o
);
  import ddft_pkg::*;

  typedef logic signed [ACC_W-1:0] acc_t;

  // Frame store and its write side.
  logic signed [SAMPLE_BITS-1:0] store_mem [FRAME_LEN];
  logic [IDX_W-1:0] wp_q;
  logic [CNT_W-1:0] fill_q;

  // Request registers and address generation.
  logic [BIN_W-1:0] bin_q;
  logic [M_W-1:0]   m_q;
  logic [IDX_W-1:0] n_q;
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W:0]   idx_sum;
  logic [IDX_W-1:0] idx_d;

  // Pipeline registers.
  logic                           v1_q;
  logic                           live1_q;
  logic signed [SAMPLE_BITS-1:0]  smp_q;
  twd_word_t                      rom_q;
  logic                           v2_q;
  logic signed [PROD_W-1:0]       prod_re_q;
  logic signed [PROD_W-1:0]       prod_im_q;
  acc_t                           acc_re_q;
  acc_t                           acc_im_q;

  logic signed [SAMPLE_BITS-1:0]  smp_eff;
  twd_t                           cos_v;
  twd_t                           sin_v;
  logic signed [PROD_W-1:0]       prod_re_d;
  logic signed [PROD_W-1:0]       prod_im_d;

  // Status back to the controller.
  assign stat_o.m_ok       = ({1'b0, m_q} < (M_W + 1)'(FRAME_LEN));
  assign stat_o.last_issue = (n_q == IDX_W'(FRAME_LEN - 1));
  assign stat_o.pipe_busy  = v1_q || v2_q;

  // Twiddle address steps by the bin, wrapping once at the frame length.
  always_comb begin
    idx_sum = {1'b0, idx_q} + {1'b0, IDX_W'(m_q)};
    if (idx_sum >= (IDX_W + 1)'(FRAME_LEN)) begin
      idx_d = IDX_W'(idx_sum - (IDX_W + 1)'(FRAME_LEN));
    end else begin
      idx_d = IDX_W'(idx_sum);
    end
  end

  // Write position and fill count; entries past the fill count read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
    end else if (cmd_i.load) begin
      if (wp_q == IDX_W'(FRAME_LEN - 1)) begin
        wp_q <= '0;
      end else begin
        wp_q <= wp_q + 1'b1;
      end
      if (fill_q != CNT_W'(FRAME_LEN)) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  // Frame store and twiddle ROM, both with registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      store_mem[wp_q] <= sample_i;
    end
    smp_q <= store_mem[n_q];
    rom_q <= TWIDDLE_ROM[idx_q];
  end

  // Pipeline valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
    end
  end

  // Bin latch, bin reduction and the read address counters.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      bin_q <= bin_index_i;
      m_q   <= M_W'(bin_index_i);
      n_q   <= '0;
      idx_q <= '0;
    end else begin
      if (cmd_i.reduce) begin
        m_q <= M_W'({1'b0, m_q} - (M_W + 1)'(FRAME_LEN));
      end
      if (cmd_i.issue) begin
        n_q   <= n_q + 1'b1;
        idx_q <= idx_d;
      end
    end
    live1_q <= ({1'b0, n_q} < fill_q);
  end

  // Products of the sample with cosine and sine.
  assign smp_eff   = live1_q ? smp_q : '0;
  assign cos_v     = twd_t'(rom_q[ROM_W-1:TWIDDLE_BITS]);
  assign sin_v     = twd_t'(rom_q[TWIDDLE_BITS-1:0]);
  assign prod_re_d = smp_eff * cos_v;
  assign prod_im_d = smp_eff * sin_v;

  always_ff @(posedge clk_i) begin
    prod_re_q <= prod_re_d;
    prod_im_q <= prod_im_d;
  end

  // Accumulators; the imaginary sum takes the negated sine products.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (v2_q) begin
      acc_re_q <= acc_re_q + acc_t'(prod_re_q);
      acc_im_q <= acc_im_q - acc_t'(prod_im_q);
    end
  end

  // Result register, held while the receiver stalls.
  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      bin_real_o   <= acc_re_q;
      bin_imag_o   <= acc_im_q;
      bin_number_o <= bin_q;
    end
  end

endmodule

@@ hdl/direct_dft_frame.sv @@
// Top level of the direct DFT frame block: controller plus datapath.
// Depends on ddft_pkg, ddft_ctrl and ddft_datapath.
//
// A load transaction (mode 0) writes one sample into the frame store in the
// cycle that it is accepted. A bin request (mode 1) occupies the block from
// bin reduction through the frame read, pipeline drain and publication: one
// read of the frame store and the twiddle ROM each cycle feeds the
// multiply-accumulate pipeline, with one product and one sum each for the
// real and imaginary parts. Input is stalled until the result is published;
// the finished result then sits in the output register, and loads or the next
// request are accepted while it waits to be taken. Store entries that were
// never written since reset read as zero through a fill count, so the block
// needs no clearing pass after reset.
module direct_dft_frame (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    mode_i,
  input  logic signed [ddft_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic [ddft_pkg::BIN_W-1:0]              bin_index_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [ddft_pkg::ACC_W-1:0]       bin_real_o,
  output logic signed [ddft_pkg::ACC_W-1:0]       bin_imag_o,
  output logic [ddft_pkg::BIN_W-1:0]              bin_number_o
);
  import ddft_pkg::*;

  ddft_cmd_t  cmd;
  ddft_stat_t stat;

  // Sequencing and handshakes.
  ddft_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // Storage and arithmetic.
  ddft_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .sample_i     (sample_i),
    .bin_index_i  (bin_index_i),
    .bin_real_o   (bin_real_o),
    .bin_imag_o   (bin_imag_o),
    .bin_number_o (bin_number_o)
  );

endmodule

@@ bench/tb_direct_dft_frame.sv @@
// Self-checking testbench for direct_dft_frame: drives sample loads and bin
// requests, predicts every bin sum and compares it with the block's results.
// Depends on ddft_pkg and the direct_dft_frame RTL.
module tb_direct_dft_frame;
  timeunit 1ns;
  timeprecision 1ps;

  import ddft_pkg::*;

  localparam int  CLK_HALF     = 5;
  localparam int  RESET_CYCLES = 9;
  localparam int  CYCLE_LIMIT  = 3_000_000;
  localparam int  DRAIN_CYCLES = FRAME_LEN + 16;
  localparam int  RANDOM_ITEMS = 560;
  localparam int  PHASE_ITEMS  = 140;
  localparam int  REQUEST_PCT  = 9;
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  // One expected bin result.
  typedef struct packed {
    logic signed [ACC_W-1:0] re_sum;
    logic signed [ACC_W-1:0] im_sum;
    logic [BIN_W-1:0]        bin;
  } bin_sum_t;

  // Frame store mirror, twiddle table and the queue of pending bin sums.
  class bin_scoreboard;
    logic signed [SAMPLE_BITS-1:0]  frame   [FRAME_LEN];
    logic signed [TWIDDLE_BITS-1:0] cos_rom [FRAME_LEN];
    logic signed [TWIDDLE_BITS-1:0] sin_rom [FRAME_LEN];
    int unsigned wr_pos;
    int          n_requests;
    int          n_errors;
    bin_sum_t    expected_q [$];

    function new();
      logic signed [TWIDDLE_BITS-1:0] c;
      logic signed [TWIDDLE_BITS-1:0] s;
      for (int k = 0; k < FRAME_LEN; k++) begin
        make_twiddle(k, c, s);
        cos_rom[k] = c;
        sin_rom[k] = s;
        frame[k]   = '0;
      end
      wr_pos     = 0;
      n_requests = 0;
      n_errors   = 0;
    endfunction

    // Clamp a Q30 magnitude to [0, 1], round half up, saturate at the top.
    function logic signed [TWIDDLE_BITS-1:0] q30_to_twiddle(longint v);
      longint w;
      longint r;
      longint top;
      w   = v;
      top = (longint'(1) << (TWIDDLE_BITS - 1)) - 1;
      if (w < 0) begin
        w = 0;
      end
      if (w > (longint'(1) << 30)) begin
        w = longint'(1) << 30;
      end
      r = (w + (longint'(1) << (30 - TWIDDLE_BITS))) >>> (31 - TWIDDLE_BITS);
      if (r > top) begin
        r = top;
      end
      return TWIDDLE_BITS'(r);
    endfunction

    // Cosine and sine of 2*pi*k/N: Taylor series on the angle within its
    // quadrant, then folded out to the full circle.
    function void make_twiddle(int k, output logic signed [TWIDDLE_BITS-1:0] co,
                               output logic signed [TWIDDLE_BITS-1:0] si);
      longint unsigned quarter;
      longint unsigned quad;
      longint unsigned rem;
      longint unsigned ang;
      longint unsigned ang2;
      longint unsigned term_s;
      longint unsigned term_c;
      longint          s_acc;
      longint          c_acc;
      logic signed [TWIDDLE_BITS-1:0] cq;
      logic signed [TWIDDLE_BITS-1:0] sq;
      quarter = longint'(k) * 4;
      quad    = quarter / FRAME_LEN;
      rem     = quarter - quad * FRAME_LEN;
      ang     = (64'd1686629713 * rem) / FRAME_LEN;
      ang2    = (ang * ang) >> 30;
      term_s  = ang;
      term_c  = 64'd1 << 30;
      s_acc   = 0;
      c_acc   = 0;
      for (int j = 0; j < 14; j++) begin
        if ((j & 1) != 0) begin
          s_acc = s_acc - $signed(term_s);
          c_acc = c_acc - $signed(term_c);
        end else begin
          s_acc = s_acc + $signed(term_s);
          c_acc = c_acc + $signed(term_c);
        end
        term_s = ((term_s * ang2) >> 30) / 64'((2 * j + 2) * (2 * j + 3));
        term_c = ((term_c * ang2) >> 30) / 64'((2 * j + 1) * (2 * j + 2));
      end
      cq = q30_to_twiddle(c_acc);
      sq = q30_to_twiddle(s_acc);
      case (quad[1:0])
        2'd0: begin
          co = cq;
          si = sq;
        end
        2'd1: begin
          co = -sq;
          si = cq;
        end
        2'd2: begin
          co = -cq;
          si = -sq;
        end
        default: begin
          co = sq;
          si = -cq;
        end
      endcase
    endfunction

    function void report_mismatch(string msg);
      n_errors++;
      if (n_errors <= 50) begin
        $display("[%0t] MISMATCH: %s", $time, msg);
      end
    endfunction

    // An accepted input transaction: store a sample or queue a bin sum.
    function void note_input(logic mode, logic signed [SAMPLE_BITS-1:0] smp,
                             logic [BIN_W-1:0] bin);
      longint   re;
      longint   im;
      int       m;
      int       idx;
      bin_sum_t e;
      if (mode == MODE_LOAD) begin
        frame[wr_pos] = smp;
        wr_pos = (wr_pos + 1) % FRAME_LEN;
      end else begin
        m  = int'(bin) % FRAME_LEN;
        re = 0;
        im = 0;
        for (int n = 0; n < FRAME_LEN; n++) begin
          idx = (n * m) % FRAME_LEN;
          re  = re + longint'(frame[n]) * longint'(cos_rom[idx]);
          im  = im - longint'(frame[n]) * longint'(sin_rom[idx]);
        end
        e.re_sum = ACC_W'(re);
        e.im_sum = ACC_W'(im);
        e.bin    = bin;
        expected_q.push_back(e);
        n_requests++;
      end
    endfunction

    // An accepted result transaction, compared with the oldest expectation.
    function void check_result(logic signed [ACC_W-1:0] re_o,
                               logic signed [ACC_W-1:0] im_o,
                               logic [BIN_W-1:0] bin_o);
      bin_sum_t e;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result for bin %0d with none pending", bin_o));
        return;
      end
      e = expected_q.pop_front();
      if (bin_o !== e.bin) begin
        report_mismatch($sformatf("bin_number %0d, want %0d", bin_o, e.bin));
      end
      if (re_o !== e.re_sum) begin
        report_mismatch($sformatf("bin %0d real %0d, want %0d", e.bin, re_o, e.re_sum));
      end
      if (im_o !== e.im_sum) begin
        report_mismatch($sformatf("bin %0d imag %0d, want %0d", e.bin, im_o, e.im_sum));
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                          clk_i        = 1'b0;
  logic                          rst_ni       = 1'b0;
  logic                          in_valid_i   = 1'b0;
  logic                          in_stall_o;
  logic                          mode_i       = MODE_LOAD;
  logic signed [SAMPLE_BITS-1:0] sample_i     = '0;
  logic [BIN_W-1:0]              bin_index_i  = '0;
  logic                          out_valid_o;
  logic                          out_stall_i  = 1'b0;
  logic signed [ACC_W-1:0]       bin_real_o;
  logic signed [ACC_W-1:0]       bin_imag_o;
  logic [BIN_W-1:0]              bin_number_o;

  bin_scoreboard sb = new();
  int            send_idle_pct  = 0;
  int            recv_stall_pct = 0;
  int            cycle_count    = 0;

  direct_dft_frame i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .sample_i     (sample_i),
    .bin_index_i  (bin_index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .bin_real_o   (bin_real_o),
    .bin_imag_o   (bin_imag_o),
    .bin_number_o (bin_number_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Run limit: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("direct_dft_frame regression: fail");
      $finish;
    end
  end

  // Result side back-pressure, at the rate of the current phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Watch both channels and hand every transaction to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_input(mode_i, sample_i, bin_index_i);
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(bin_real_o, bin_imag_o, bin_number_o);
      end
    end
  end

  // Phases: none idle, sender idle, receiver stalling, both lightly.
  task automatic set_phase(input int p);
    case (p)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 77;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 77;
      end
      default: begin
        send_idle_pct  = 13;
        recv_stall_pct = 13;
      end
    endcase
  endtask

  // Offer one transaction, after a random gap, and hold it until taken.
  task automatic send_item(input logic mode, input logic signed [SAMPLE_BITS-1:0] smp,
                           input logic [BIN_W-1:0] bin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= mode;
    sample_i    <= smp;
    bin_index_i <= bin;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(0, 11))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3:       return 16'shFFFF;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [BIN_W-1:0] random_bin();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return BIN_W'(FRAME_LEN / 2);
      default: return BIN_W'($urandom_range(0, (1 << BIN_W) - 1));
    endcase
  endfunction

  initial begin
    int n_rand;
    set_phase(0);
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Requests on the empty store, where every entry still reads as zero.
    send_item(MODE_REQUEST, 16'sh1234, 10'd0);
    send_item(MODE_REQUEST, 16'sh0000, 10'd1023);
    // Extreme samples into a partly loaded frame.
    send_item(MODE_LOAD, 16'sh7FFF, 10'd0);
    send_item(MODE_LOAD, 16'sh8000, 10'd1023);
    send_item(MODE_LOAD, 16'sh0000, 10'h155);
    send_item(MODE_LOAD, 16'shFFFF, 10'h2AA);
    send_item(MODE_LOAD, 16'sh0001, 10'd0);
    send_item(MODE_LOAD, 16'sh5555, 10'd0);
    send_item(MODE_LOAD, 16'shAAAA, 10'd0);
    // Bins at the edges, the quarter points and alternating bit patterns.
    send_item(MODE_REQUEST, 16'sh7FFF, 10'd0);
    send_item(MODE_REQUEST, 16'sh8000, 10'd1);
    send_item(MODE_REQUEST, 16'sh0000, 10'd256);
    send_item(MODE_REQUEST, 16'sh0000, 10'd512);
    send_item(MODE_REQUEST, 16'sh0000, 10'd768);
    send_item(MODE_REQUEST, 16'sh0000, 10'd1023);
    send_item(MODE_REQUEST, 16'sh0000, 10'h155);
    send_item(MODE_REQUEST, 16'sh0000, 10'h2AA);
    send_item(MODE_LOAD, 16'sh8000, 10'd0);
    send_item(MODE_LOAD, 16'sh8000, 10'd0);
    send_item(MODE_LOAD, 16'sh8000, 10'd0);
    send_item(MODE_REQUEST, 16'sh0000, 10'd512);

    // Random loads with requests among them.
    n_rand = 0;
    while (n_rand < RANDOM_ITEMS) begin
      set_phase((n_rand / PHASE_ITEMS) % 4);
      if ($urandom_range(0, 99) < REQUEST_PCT) begin
        send_item(MODE_REQUEST, random_sample(), random_bin());
      end else begin
        send_item(MODE_LOAD, random_sample(), random_bin());
      end
      n_rand++;
    end
    in_valid_i <= 1'b0;

    // Drain: every bin sum back, then a quiet spell for stray results.
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("direct_dft_frame regression: pass");
    end else begin
      $display("direct_dft_frame regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/ddft_pkg.sv
hdl/ddft_ctrl.sv
hdl/ddft_datapath.sv
hdl/direct_dft_frame.sv
bench/tb_direct_dft_frame.sv
